// ===== hw/rtl/pblru_pkg.sv =====
// Package: shared types, command and action codes for the page buffer slot manager.
`default_nettype none
package pblru_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int FILE_BITS_DEF = 8;
  localparam int PIN_BITS_DEF = 16;

  typedef enum logic [2:0] {
    CMD_GET = 3'd0, CMD_DIRTY = 3'd1, CMD_UNPIN = 3'd2, CMD_FLUSH = 3'd3,
    CMD_FLUSH_ALL = 3'd4, CMD_FLUSH_FILE = 3'd5, CMD_CONTAINS = 3'd6, CMD_NONE = 3'd7
  } cmd_t;

  localparam logic [2:0] ACT_DONE     = 3'd0;
  localparam logic [2:0] ACT_HIT      = 3'd1;
  localparam logic [2:0] ACT_LOAD     = 3'd2;
  localparam logic [2:0] ACT_WB       = 3'd3;
  localparam logic [2:0] ACT_NOVICTIM = 3'd4;
  localparam logic [2:0] ACT_ABSENT   = 3'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  file_id;
    logic [31:0] page_no;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot;
    logic [7:0]  out_file;
    logic [31:0] out_page;
    logic        present;
    logic        last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/page_buffer_lru_pin_manager_top.sv =====
// Top level: command sequencer that scans the slot cells one per cycle.
//
//  channel | ports                      | transaction
//  input   | start, busy, in_item       | start high while busy low
//  result  | out_valid, out_item        | one cycle per result, no stall
//
// A command scans the slots one per cycle, then spends an execute state on update
// and result; an eviction adds a load state, dirty or not. Results are registered
// and appear in the cycle after the step that makes them; flush-all and flush-file
// commands emit write-backs during the scan. Busy drops in the cycle that presents
// the last result, so the next command is taken no earlier than that cycle. Reset
// is synchronous and empties the table at once.
`default_nettype none
module page_buffer_lru_pin_manager_top import pblru_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int FILE_BITS = FILE_BITS_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);
  localparam int RW = $clog2(SLOTS);
  localparam int UW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_LOAD} state_t;
  state_t state_r;

  logic [2:0]            cmd_r;
  logic [FILE_BITS-1:0]  kfile_r;
  logic [31:0]           kpage_r;
  logic [RW-1:0]         pos_r, hit_r, vic_r;
  logic                  found_r, vfound_r;
  logic [UW-1:0]         used_r;

  logic [SLOTS-1:0] tok, valid_v, match_v, dirty_v, pinned_v, sel_v;
  logic [RW-1:0]    rank_v [SLOTS];
  logic [FILE_BITS-1:0] file_v [SLOTS];
  logic [31:0]      page_v [SLOTS];

  logic op_fill, op_pin, op_unpin, op_sd, op_cd, op_age, age_all;
  logic [RW-1:0] sel_idx, age_below;
  logic tok_seed;

  assign tok_seed = (state_r == S_IDLE) && start;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    pblru_cell #(.SLOTS(SLOTS), .FILE_BITS(FILE_BITS), .PIN_BITS(PIN_BITS)) u_cell (
      .clk, .rst_n,
      .tok_in(i == 0 ? tok_seed : tok[(i == 0) ? 0 : i-1]), .tok_out(tok[i]),
      .key_file(kfile_r), .key_page(kpage_r),
      .valid(valid_v[i]), .match(match_v[i]), .dirty(dirty_v[i]),
      .pinned(pinned_v[i]), .rank(rank_v[i]), .file_o(file_v[i]), .page_o(page_v[i]),
      .sel(sel_v[i]), .do_fill(op_fill), .do_pin(op_pin), .do_unpin(op_unpin),
      .do_set_dirty(op_sd), .do_clr_dirty(op_cd), .do_age(op_age),
      .age_below(age_below), .age_all(age_all));
    assign sel_v[i] = sel_idx == RW'(i);
  end

  // The cell holding the token is the one examined in the scan state.
  logic cur_v, cur_m, cur_d, cur_p;
  logic [FILE_BITS-1:0] cur_f;
  logic [31:0] cur_pg;
  logic [RW-1:0] cur_rank;
  logic flush_hit;
  assign cur_v = valid_v[pos_r];
  assign cur_m = match_v[pos_r];
  assign cur_d = dirty_v[pos_r];
  assign cur_p = pinned_v[pos_r];
  assign cur_f = file_v[pos_r];
  assign cur_pg = page_v[pos_r];
  assign cur_rank = rank_v[pos_r];
  assign flush_hit = state_r == S_SCAN && cur_v && cur_d &&
                     (cmd_r == CMD_FLUSH_ALL || (cmd_r == CMD_FLUSH_FILE && cur_f == kfile_r));

  logic full;
  assign full = used_r == UW'(SLOTS);

  always_comb begin
    op_fill = 1'b0; op_pin = 1'b0; op_unpin = 1'b0; op_sd = 1'b0; op_cd = 1'b0;
    op_age = 1'b0; age_all = 1'b0; age_below = '0; sel_idx = pos_r;
    if (flush_hit) op_cd = 1'b1;
    if (state_r == S_EXEC && found_r) begin
      sel_idx = hit_r;
      unique case (cmd_r)
        CMD_GET: begin
          op_pin = 1'b1; op_age = 1'b1; age_below = rank_v[hit_r];
        end
        CMD_DIRTY: op_sd = 1'b1;
        CMD_UNPIN: op_unpin = 1'b1;
        CMD_FLUSH: op_cd = 1'b1;
        default: ;
      endcase
    end else if (state_r == S_EXEC && cmd_r == CMD_GET && !full) begin
      sel_idx = RW'(used_r); op_fill = 1'b1; op_age = 1'b1; age_all = 1'b1;
    end else if (state_r == S_LOAD) begin
      sel_idx = vic_r; op_fill = 1'b1; op_age = 1'b1; age_below = rank_v[vic_r];
    end
  end

  out_item_t res;
  logic res_v;
  always_comb begin
    res = '0; res_v = 1'b0;
    if (flush_hit) begin
      res_v = 1'b1; res.action = ACT_WB; res.slot = 4'(pos_r);
      res.out_file = 8'(cur_f); res.out_page = cur_pg;
    end else if (state_r == S_EXEC) begin
      res_v = 1'b1; res.last = 1'b1;
      case (cmd_r) inside
        CMD_GET: begin
          res.out_file = 8'(kfile_r); res.out_page = kpage_r;
          if (found_r) begin
            res.action = ACT_HIT; res.slot = 4'(hit_r);
          end else if (!full) begin
            res.action = ACT_LOAD; res.slot = 4'(used_r);
          end else if (!vfound_r) begin
            res.action = ACT_NOVICTIM; res.out_file = '0; res.out_page = '0;
          end else if (dirty_v[vic_r]) begin
            res.action = ACT_WB; res.slot = 4'(vic_r); res.last = 1'b0;
            res.out_file = 8'(file_v[vic_r]); res.out_page = page_v[vic_r];
          end else res_v = 1'b0;
        end
        CMD_DIRTY, CMD_UNPIN, CMD_FLUSH: begin
          if (!found_r) res.action = ACT_ABSENT;
          else if (cmd_r == CMD_FLUSH && dirty_v[hit_r]) begin
            res.action = ACT_WB; res.slot = 4'(hit_r);
            res.out_file = 8'(file_v[hit_r]); res.out_page = page_v[hit_r];
          end else begin
            res.action = ACT_DONE; res.slot = 4'(hit_r);
          end
        end
        CMD_CONTAINS: begin
          res.present = found_r; res.slot = found_r ? 4'(hit_r) : 4'd0;
        end
        default: ;
      endcase
    end else if (state_r == S_LOAD) begin
      res_v = 1'b1; res.last = 1'b1; res.action = ACT_LOAD; res.slot = 4'(vic_r);
      res.out_file = 8'(kfile_r); res.out_page = kpage_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_v;
      out_item <= res;
      unique case (state_r)
        S_IDLE: if (start) begin
          state_r <= S_SCAN;
          cmd_r <= in_item.command;
          kfile_r <= FILE_BITS'(in_item.file_id);
          kpage_r <= in_item.page_no;
          pos_r <= '0; found_r <= 1'b0; vfound_r <= 1'b0;
        end
        S_SCAN: begin
          if (cur_m && !found_r) begin
            found_r <= 1'b1; hit_r <= pos_r;
          end
          if (cur_v && !cur_p && (!vfound_r || cur_rank > rank_v[vic_r])) begin
            vfound_r <= 1'b1; vic_r <= pos_r;
          end
          // The token sits in the last cell on the final scan cycle.
          if (tok[SLOTS-1]) state_r <= S_EXEC;
          else pos_r <= pos_r + 1'b1;
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          if (cmd_r == CMD_GET && !found_r) begin
            if (!full) used_r <= used_r + 1'b1;
            else if (vfound_r) state_r <= S_LOAD;
          end
        end
        S_LOAD: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = state_r != S_IDLE;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n) used_r <= UW'(SLOTS))
    else $error("slot count overflow");
  a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> res_v && res.last) else $error("eviction load missing");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> !out_valid || $past(res_v)) else $error("stray result");
endmodule
`default_nettype wire

// ===== hw/rtl/pblru_cell.sv =====
// Slot cell: one table entry, its match logic and its position in the scan chain.
`default_nettype none
module pblru_cell import pblru_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int FILE_BITS = FILE_BITS_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Token travels along the chain; the cell holding it is examined this cycle.
  input  wire logic                     tok_in,
  output logic                          tok_out,
  input  wire logic [FILE_BITS-1:0]     key_file,
  input  wire logic [31:0]              key_page,
  output logic                          valid,
  output logic                          match,
  output logic                          dirty,
  output logic                          pinned,
  output logic [$clog2(SLOTS)-1:0]      rank,
  output logic [FILE_BITS-1:0]          file_o,
  output logic [31:0]                   page_o,
  // Operations broadcast by the controller.
  input  wire logic                     sel,
  input  wire logic                     do_fill,
  input  wire logic                     do_pin,
  input  wire logic                     do_unpin,
  input  wire logic                     do_set_dirty,
  input  wire logic                     do_clr_dirty,
  input  wire logic                     do_age,
  input  wire logic [$clog2(SLOTS)-1:0] age_below,
  input  wire logic                     age_all
);
  localparam int RW = $clog2(SLOTS);
  logic                 valid_r, dirty_r;
  logic [PIN_BITS-1:0]  pins_r;
  logic [RW-1:0]        rank_r;
  logic [FILE_BITS-1:0] file_r;
  logic [31:0]          page_r;

  assign valid = valid_r;
  assign dirty = dirty_r;
  assign pinned = pins_r != '0;
  assign rank = rank_r;
  assign file_o = file_r;
  assign page_o = page_r;
  assign match = valid_r && file_r == key_file && page_r == key_page;

  always_ff @(posedge clk) begin
    tok_out <= rst_n ? tok_in : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      pins_r <= '0;
    end else begin
      if (do_age && valid_r && !sel && (age_all || rank_r < age_below))
        rank_r <= rank_r + 1'b1;
      if (sel) begin
        if (do_fill) begin
          valid_r <= 1'b1;
          file_r <= key_file;
          page_r <= key_page;
          dirty_r <= 1'b0;
          pins_r <= PIN_BITS'(1);
          rank_r <= '0;
        end
        if (do_pin) begin
          rank_r <= '0;
          if (pins_r != '1) pins_r <= pins_r + 1'b1;
        end
        if (do_unpin && pins_r != '0) pins_r <= pins_r - 1'b1;
        if (do_set_dirty) dirty_r <= 1'b1;
        if (do_clr_dirty) dirty_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
